[rtl/idt_pkg.sv]
package idt_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int INDENT_BITS = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int TAB_W       = 5;
  localparam int NEST_W      = 5;
  localparam int CHAR_W      = 8;

  localparam logic [TAB_W-1:0]       TAB_RESET  = TAB_W'(4);
  localparam logic [INDENT_BITS-1:0] INDENT_MAX = {INDENT_BITS{1'b1}};
  localparam logic [SP_W-1:0]        SP_FULL    = SP_W'(STACK_DEPTH - 1);

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
  localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_SAME     = 3'd1,
    EV_BEGIN    = 3'd2,
    EV_END      = 3'd3,
    EV_MISMATCH = 3'd4,
    EV_OVERFLOW = 3'd5
  } ev_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_MISM
  } state_t;

  // Line indentation handed from the scanner to the stack controller.
  typedef struct packed {
    logic                   fire;
    logic                   slash;
    logic [INDENT_BITS-1:0] ind;
  } fin_t;

endpackage

[rtl/idt_stack_ram.sv]
module idt_stack_ram (
  input  logic                            clk,
  input  logic                            we,
  input  logic [idt_pkg::SP_W-1:0]        waddr,
  input  logic [idt_pkg::INDENT_BITS-1:0] wdata,
  input  logic [idt_pkg::SP_W-1:0]        raddr,
  output logic [idt_pkg::INDENT_BITS-1:0] rdata
);
  import idt_pkg::*;

  logic [INDENT_BITS-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Write-first read so a push is visible to the very next pop.
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/idt_scan.sv]
module idt_scan (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [idt_pkg::TAB_W-1:0]  cfg_wr_data,
  input  logic                       accept,
  input  logic [idt_pkg::CHAR_W-1:0] char_in,
  input  logic                       line_start,
  output idt_pkg::fin_t              fin
);
  import idt_pkg::*;

  logic [TAB_W-1:0]       tab_width;
  logic                   counting, counting_next;
  logic                   slash_pend, slash_pend_next;
  logic                   in_cmt, in_cmt_next;
  logic [INDENT_BITS-1:0] acc, acc_next;
  logic [INDENT_BITS-1:0] eff_acc;
  logic                   eff_sl, eff_cm;
  logic [TAB_W-1:0]       amount;
  logic [INDENT_BITS:0]   sum;

  assign eff_acc = counting ? acc : '0;
  assign eff_sl  = counting & slash_pend;
  assign eff_cm  = counting & in_cmt;
  assign amount  = (char_in == CH_TAB) ? tab_width : TAB_W'(1);
  assign sum     = {1'b0, eff_acc} + (INDENT_BITS + 1)'(amount);

  always_comb begin
    counting_next   = counting;
    slash_pend_next = slash_pend;
    in_cmt_next     = in_cmt;
    acc_next        = acc;
    fin             = '0;
    if (accept && (counting || line_start)) begin
      counting_next   = 1'b1;
      slash_pend_next = eff_sl;
      in_cmt_next     = eff_cm;
      acc_next        = eff_acc;
      fin.ind         = eff_acc;
      if (eff_cm) begin
        if (char_in == CH_LF) begin
          in_cmt_next = 1'b0;
          acc_next    = '0;
        end else if (char_in == CH_NUL) begin
          fin.fire = 1'b1;
        end
      end else if (eff_sl) begin
        if (char_in == CH_SLASH) begin
          slash_pend_next = 1'b0;
          in_cmt_next     = 1'b1;
        end else begin
          fin.fire  = 1'b1;
          fin.slash = 1'b1;
        end
      end else begin
        case (char_in) inside
          CH_SPACE, CH_VT, CH_FF, CH_TAB: begin
            acc_next = sum[INDENT_BITS] ? INDENT_MAX : sum[INDENT_BITS-1:0];
          end
          CH_LF: begin
            acc_next = '0;
          end
          CH_SLASH: begin
            slash_pend_next = 1'b1;
          end
          default: begin
            fin.fire = 1'b1;
          end
        endcase
      end
      if (fin.fire) begin
        counting_next   = 1'b0;
        slash_pend_next = 1'b0;
        in_cmt_next     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_width  <= TAB_RESET;
      counting   <= 1'b1;
      slash_pend <= 1'b0;
      in_cmt     <= 1'b0;
      acc        <= '0;
    end else begin
      if (cfg_wr_en) begin
        tab_width <= cfg_wr_data;
      end
      counting   <= counting_next;
      slash_pend <= slash_pend_next;
      in_cmt     <= in_cmt_next;
      acc        <= acc_next;
    end
  end

endmodule

[rtl/idt_stack_ctrl.sv]
module idt_stack_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  idt_pkg::fin_t              fin,
  output logic                       in_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  output idt_pkg::ev_t               out_ev,
  output logic                       out_slash,
  output logic                       out_last,
  output logic [idt_pkg::NEST_W-1:0] out_depth
);
  import idt_pkg::*;

  state_t                 state, state_next;
  logic [SP_W-1:0]        sp, sp_next, sp_dec;
  logic [INDENT_BITS-1:0] top_val, top_next;
  logic [INDENT_BITS-1:0] ind_q, ind_next, cmp_ind, next_top, rd_data;
  logic                   slash_q, slash_next;
  logic                   out_free, load, load_last, push;
  ev_t                    load_ev;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) && out_free;
  assign sp_dec   = sp - 1'b1;
  assign next_top = (sp_dec == '0) ? '0 : rd_data;
  assign cmp_ind  = (state == ST_IDLE) ? fin.ind : ind_q;

  idt_stack_ram u_ram (
    .clk   (clk),
    .we    (push),
    .waddr (sp),
    .wdata (top_val),
    .raddr (sp_next - 1'b1),
    .rdata (rd_data)
  );

  always_comb begin
    state_next = state;
    sp_next    = sp;
    top_next   = top_val;
    ind_next   = ind_q;
    slash_next = slash_q;
    load       = 1'b0;
    load_ev    = EV_SAME;
    load_last  = 1'b1;
    push       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (fin.fire) begin
          ind_next   = fin.ind;
          slash_next = fin.slash;
          load       = 1'b1;
          if (fin.ind > top_val) begin
            if (sp == SP_FULL) begin
              load_ev = EV_OVERFLOW;
            end else begin
              load_ev  = EV_BEGIN;
              push     = 1'b1;
              sp_next  = sp + 1'b1;
              top_next = fin.ind;
            end
          end else if (fin.ind < top_val) begin
            state_next = ST_POP;
          end
        end
      end
      ST_POP, ST_MISM: begin
      end
      default: begin
      end
    endcase
    // One pop per cycle when out_free; RAM always holds the entry below the top.
    if ((state == ST_POP && out_free) || (state == ST_IDLE && state_next == ST_POP)) begin
      load     = 1'b1;
      load_ev  = EV_END;
      sp_next  = sp_dec;
      top_next = next_top;
      if (cmp_ind == next_top) begin
        state_next = ST_IDLE;
      end else begin
        load_last  = 1'b0;
        state_next = (cmp_ind < next_top) ? ST_POP : ST_MISM;
      end
    end
    if (state == ST_MISM && out_free) begin
      load       = 1'b1;
      load_ev    = EV_MISMATCH;
      state_next = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sp        <= '0;
      top_val   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      sp      <= sp_next;
      top_val <= top_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ind_q   <= ind_next;
    slash_q <= slash_next;
    if (load) begin
      out_ev    <= load_ev;
      out_slash <= (state == ST_IDLE) ? fin.slash : slash_q;
      out_last  <= load_last;
      out_depth <= NEST_W'(sp_next);
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready)
    else $error("input taken while a dedent run is in progress");

  a_pop_dec: assert property (@(posedge clk) disable iff (rst)
    (load && load_ev == EV_END) |=> (sp == $past(sp_dec)))
    else $error("block end without a pop");

  a_push_deeper: assert property (@(posedge clk) disable iff (rst)
    (load && load_ev == EV_BEGIN) |=> (top_val > $past(top_val)))
    else $error("push did not deepen the top level");

  a_run_open: assert property (@(posedge clk) disable iff (rst)
    (load && !load_last) |=> (state != ST_IDLE))
    else $error("run ended without a final result");

endmodule

[rtl/indent_block_tracker.sv]
// Indentation block tracker: finds block nesting from leading whitespace.
// Input channel (s_*): one source byte per transfer in s_tdata, with the
// line-start flag in s_tuser. Spaces, vertical tabs and form feeds add one
// column, a tab adds tab_width columns, a newline restarts the count and a
// line opening with // is skipped. The first other byte closes the count.
// Output channel (m_*): nest_depth in m_tdata, event code and held-slash flag
// in m_tuser, m_tlast on the final result of the byte that caused it.
// Throughput: one byte per cycle while s_tready is high. A byte that closes a
// count produces its first result in the cycle after its transfer. A dedent
// occupies the block until its last result is loaded, as the stack controller
// pops one level per cycle while the output is free, from the level RAM, whose
// read is registered. The output register lets a new byte be taken in the same
// cycle that the last result is taken. When the receiver stalls, the result
// stays in the output register and s_tready drops until it is taken.
// Reset (rst, synchronous) sets tab_width to 4, starts counting at column 0
// and empties the stack; no RAM clearing pass is needed. The block relies on
// the user to have tab_width written through cfg_wr_en/cfg_wr_data while idle.
module indent_block_tracker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [4:0] cfg_wr_data,  // tab_width
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,      // [7:0] char_in
  input  logic [0:0] s_tuser,      // [0] line_start
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,      // [4:0] nest_depth, upper bits zero
  output logic [3:0] m_tuser,      // [2:0] event_res, [3] slash_held
  output logic       m_tlast       // last_of_run
);
  import idt_pkg::*;

  fin_t              fin;
  logic              accept;
  ev_t               out_ev;
  logic              out_slash;
  logic [NEST_W-1:0] out_depth;

  // A transfer on the input side happens when both handshake signals are high.
  assign accept = s_tvalid && s_tready;

  idt_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .char_in     (s_tdata),
    .line_start  (s_tuser[0]),
    .fin         (fin)
  );

  idt_stack_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fin       (fin),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_ev    (out_ev),
    .out_slash (out_slash),
    .out_last  (m_tlast),
    .out_depth (out_depth)
  );

  // Results are packed low field first; unused data bits stay zero.
  assign m_tdata = {(8 - NEST_W)'(0), out_depth};
  assign m_tuser = {out_slash, out_ev};

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import idt_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int SETTLE       = 8;      // cycles allowed for bytes that leave no result
  localparam int LONG_HOLD    = 300;    // receiver hold-off used to fill the block
  localparam int MAX_PRINTS   = 20;
  localparam int TIMEOUT_NS   = 2_000_000;

  // Receiver behavior while it is not in a long hold-off.
  localparam int RX_ALWAYS  = 0;
  localparam int RX_RANDOM  = 1;
  localparam int RX_PATTERN = 2;

  // One block event as it leaves the output stream.
  typedef struct packed {
    ev_t               code;
    logic              slash;
    logic              last;
    logic [NEST_W-1:0] depth;
  } nest_result_t;

  logic       clk         = 1'b0;
  logic       rst         = 1'b1;
  logic       cfg_wr_en   = 1'b0;
  logic [4:0] cfg_wr_data = '0;
  logic       s_tvalid    = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata     = '0;
  logic [0:0] s_tuser     = '0;
  logic       m_tvalid;
  logic       m_tready    = 1'b0;
  logic [7:0] m_tdata;
  logic [3:0] m_tuser;
  logic       m_tlast;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  indent_block_tracker DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  // ---------------------------------------------------------------------------
  // Nesting predictor. It mirrors the tracker's scanner and indentation stack
  // and queues the events that each accepted byte must produce.
  // ---------------------------------------------------------------------------
  logic [TAB_W-1:0]       tab_w      = TAB_RESET;
  bit                     counting   = 1'b1;   // start of source counts at once
  bit                     slash_pend = 1'b0;
  bit                     in_comment = 1'b0;
  logic [INDENT_BITS-1:0] indent_cnt = '0;
  logic [INDENT_BITS-1:0] levels [STACK_DEPTH] = '{default: '0};
  logic [SP_W-1:0]        sp         = '0;

  nest_result_t expected_events[$];
  int           bytes_used  = 0;   // bytes that were not simply ignored
  int           mismatches  = 0;

  function automatic void add_columns(input logic [TAB_W-1:0] amount);
    logic [INDENT_BITS:0] total;
    total = {1'b0, indent_cnt} + (INDENT_BITS + 1)'(amount);
    indent_cnt = (total > INDENT_MAX) ? INDENT_MAX : total[INDENT_BITS-1:0];
  endfunction

  // Compare the finished count with the top of the stack and queue the events.
  function automatic void close_line(input logic slash);
    logic [INDENT_BITS-1:0] ind;
    ev_t                    codes[$];
    logic [NEST_W-1:0]      depths[$];
    nest_result_t           r;
    ind = indent_cnt;
    counting   = 1'b0;
    slash_pend = 1'b0;
    in_comment = 1'b0;
    if (ind > levels[sp]) begin
      if (sp == SP_FULL) begin
        // A full stack reports overflow and stays as it is.
        codes.push_back(EV_OVERFLOW);
        depths.push_back(sp);
      end else begin
        sp++;
        levels[sp] = ind;
        codes.push_back(EV_BEGIN);
        depths.push_back(sp);
      end
    end else if (ind < levels[sp]) begin
      while (ind < levels[sp] && sp != 0) begin
        sp--;
        codes.push_back(EV_END);
        depths.push_back(sp);
      end
      // A dedent that lands between two levels ends with a mismatch.
      if (ind != levels[sp]) begin
        codes.push_back(EV_MISMATCH);
        depths.push_back(sp);
      end
    end else begin
      codes.push_back(EV_SAME);
      depths.push_back(sp);
    end
    for (int i = 0; i < codes.size(); i++) begin
      r.code  = codes[i];
      r.slash = slash;
      r.last  = (i == codes.size() - 1);
      r.depth = depths[i];
      expected_events.push_back(r);
    end
  endfunction

  // Returns 0 when the byte is ignored (no count running, no line start).
  function automatic bit predict_byte(input logic [7:0] ch, input logic ls);
    if (!counting) begin
      if (!ls) return 1'b0;
      counting   = 1'b1;
      indent_cnt = '0;
      slash_pend = 1'b0;
      in_comment = 1'b0;
    end
    if (in_comment) begin
      if (ch == CH_LF) begin
        in_comment = 1'b0;
        indent_cnt = '0;
      end else if (ch == CH_NUL) begin
        // End of input inside a comment line uses the count before the //.
        close_line(1'b0);
      end
      return 1'b1;
    end
    if (slash_pend) begin
      if (ch == CH_SLASH) begin
        slash_pend = 1'b0;
        in_comment = 1'b1;
      end else begin
        close_line(1'b1);
      end
      return 1'b1;
    end
    case (ch) inside
      CH_SPACE, CH_VT, CH_FF: add_columns(TAB_W'(1));
      CH_TAB:   add_columns(tab_w);
      CH_LF:    indent_cnt = '0;
      CH_SLASH: slash_pend = 1'b1;
      default:  close_line(1'b0);
    endcase
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: the receiver stalls on its own, and every accepted result is
  // compared with the oldest queued event.
  // ---------------------------------------------------------------------------
  int         rx_mode     = RX_ALWAYS;
  int         holdoff_req = 0;          // bumped by a test to ask for a long hold-off
  logic [7:0] rx_pattern  = 8'b1100_1011;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("%0t ns: %s", $time, what);
  endtask

  initial begin : receiver
    int holdoff_seen;
    holdoff_seen = 0;
    forever begin
      @(posedge clk);
      if (holdoff_req != holdoff_seen) begin
        // Long stall while the sender keeps offering bytes, so the block backs up.
        holdoff_seen = holdoff_req;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        case (rx_mode)
          RX_RANDOM: m_tready <= ($urandom_range(0, 99) >= 35);
          RX_PATTERN: begin
            rx_pattern = {rx_pattern[6:0], rx_pattern[7]};
            m_tready <= rx_pattern[0];
          end
          default: m_tready <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk) begin : result_check
    nest_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("unexpected result: code %0d depth %0d",
                                  m_tuser[2:0], m_tdata));
      end else begin
        want = expected_events.pop_front();
        if (m_tuser[2:0] !== want.code || m_tuser[3] !== want.slash ||
            m_tlast !== want.last || m_tdata !== {3'b000, want.depth}) begin
          report_mismatch($sformatf(
            "result got code %0d slash %0b last %0b depth %0d, want %0d %0b %0b %0d",
            m_tuser[2:0], m_tuser[3], m_tlast, m_tdata,
            want.code, want.slash, want.last, want.depth));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte side. Bytes go out in bursts with random gaps when bursty is set.
  // ---------------------------------------------------------------------------
  bit bursty     = 1'b0;
  int burst_left = 0;
  bit line_flag  = 1'b0;   // line_start for the first byte of the next line

  task automatic send_byte(input logic [7:0] ch, input logic ls);
    int gap;
    if (!s_tvalid) s_tvalid <= 1'b1;
    s_tdata <= ch;
    s_tuser <= ls;
    do @(posedge clk); while (!s_tready);
    if (predict_byte(ch, ls)) bytes_used++;
    if (bursty) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 16);
        gap = $urandom_range(1, 6);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // While a count runs the line-start flag is ignored, so it is set at random.
  task automatic put_byte(input logic [7:0] ch);
    logic ls;
    ls = line_flag || (counting && $urandom_range(0, 11) == 0);
    line_flag = 1'b0;
    send_byte(ch, ls);
  endtask

  // Wait for every queued event, then a little longer for bytes without one.
  task automatic drain_results();
    if (s_tvalid) s_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_tab_width(input logic [4:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tab_w = value;
    @(posedge clk);
  endtask

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF;
  endfunction

  // A byte that starts line content: never whitespace, a slash or end of input.
  function automatic logic [7:0] pick_content();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (is_blank(c) || c == CH_SLASH);
    return c;
  endfunction

  // Emit whitespace worth exactly cols columns, mixing tabs, spaces, VT and FF.
  task automatic send_indent(input int cols);
    int left;
    left = cols;
    while (left > 0) begin
      if (tab_w != 0 && tab_w <= left && $urandom_range(0, 2) == 0) begin
        put_byte(CH_TAB);
        left -= tab_w;
      end else begin
        case ($urandom_range(0, 5))
          0:       put_byte(CH_VT);
          1:       put_byte(CH_FF);
          default: put_byte(CH_SPACE);
        endcase
        left--;
      end
    end
    if (tab_w == 0 && $urandom_range(0, 3) == 0) put_byte(CH_TAB);
  endtask

  task automatic send_line(input int cols, input logic [7:0] content);
    line_flag = 1'b1;
    send_indent(cols);
    put_byte(content);
  endtask

  // A line indented with as many tabs as fit, then spaces; tab_w must be nonzero.
  task automatic send_packed_line(input int cols, input logic [7:0] content);
    line_flag = 1'b1;
    repeat (cols / int'(tab_w)) put_byte(CH_TAB);
    repeat (cols % int'(tab_w)) put_byte(CH_SPACE);
    put_byte(content);
  endtask

  function automatic int pick_indent();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return int'(levels[sp]);
    if (r < 60) return int'(levels[sp]) + $urandom_range(1, 6);
    if (r < 90) return int'(levels[SP_W'($urandom_range(0, sp))]);
    return $urandom_range(0, 40);
  endfunction

  // Mostly well-formed lines that steer the stack; some blank, comment, slash
  // and end-of-input lines; a few bursts of raw noise.
  task automatic send_random_line();
    int         kind;
    logic [7:0] c;
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      repeat ($urandom_range(1, 6)) begin
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end
    end else begin
      line_flag = 1'b1;
      send_indent(pick_indent());
      if (kind < 14) begin
        put_byte(CH_LF);
      end else if (kind < 22) begin
        put_byte(CH_SLASH);
        put_byte(CH_SLASH);
        repeat ($urandom_range(0, 3)) put_byte(pick_content());
        put_byte(CH_LF);
      end else if (kind < 28) begin
        put_byte(CH_SLASH);
        do c = 8'($urandom_range(0, 255)); while (c == CH_SLASH);
        put_byte(c);
      end else if (kind < 31) begin
        if ($urandom_range(0, 1)) begin
          put_byte(CH_SLASH);
          put_byte(CH_SLASH);
        end
        put_byte(CH_NUL);
      end else begin
        put_byte(pick_content());
        if ($urandom_range(0, 3) == 0) put_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Same level, a push, a tab at the reset width, a two-level dedent and a
  // dedent that lands between levels.
  task automatic test_nesting();
    send_line(0, "a");
    send_line(4, "b");
    line_flag = 1'b1;
    put_byte(CH_TAB);
    put_byte("c");
    send_line(8, "d");
    send_line(0, "e");
    send_line(8, "f");
    send_line(3, "g");
    send_line(0, "h");
  endtask

  // VT and FF count one column, a newline restarts the count, bytes outside a
  // count without line start are ignored, and line start is ignored mid-count.
  task automatic test_whitespace();
    line_flag = 1'b1;
    put_byte(CH_VT);
    put_byte(CH_FF);
    put_byte(CH_SPACE);
    put_byte(CH_LF);
    put_byte(CH_SPACE);
    put_byte(CH_FF);
    put_byte(8'hFF);
    put_byte("i");
    send_byte(CH_SPACE, 1'b1);
    send_byte(CH_VT, 1'b1);
    send_byte("j", 1'b1);
    line_flag = 1'b1;
    put_byte(CH_NUL);
  endtask

  // Comment lines are skipped, a lone slash is handed back with the next byte
  // whatever it is, and end of input inside a comment closes the count.
  task automatic test_comments();
    line_flag = 1'b1;
    send_indent(2);
    put_byte(CH_SLASH);
    put_byte(CH_SLASH);
    put_byte("q");
    put_byte(CH_LF);
    send_indent(2);
    put_byte("r");
    line_flag = 1'b1;
    send_indent(2);
    put_byte(CH_SLASH);
    put_byte("s");
    line_flag = 1'b1;
    put_byte(CH_SLASH);
    put_byte(CH_SPACE);
    line_flag = 1'b1;
    send_indent(6);
    put_byte(CH_SLASH);
    put_byte(CH_LF);
    line_flag = 1'b1;
    send_indent(6);
    put_byte(CH_SLASH);
    put_byte(CH_NUL);
    line_flag = 1'b1;
    send_indent(3);
    put_byte(CH_SLASH);
    put_byte(CH_SLASH);
    put_byte("x");
    put_byte(CH_NUL);
  endtask

  // Tab widths at the edges of the useful range and outside it.
  task automatic test_tab_widths();
    logic [4:0] widths [4] = '{5'd1, 5'd16, 5'd0, 5'd31};
    foreach (widths[i]) begin
      drain_results();
      write_tab_width(widths[i]);
      line_flag = 1'b1;
      put_byte(CH_TAB);
      put_byte(CH_TAB);
      put_byte(CH_SPACE);
      put_byte("k");
      send_line(0, "m");
    end
  endtask

  // Fill the stack, push once more for overflow, then one dedent that pops
  // every level and ends in a mismatch: the longest run a byte can cause.
  task automatic test_stack_limits();
    drain_results();
    write_tab_width(5'd6);
    send_line(0, "a");
    for (int d = 2; d <= STACK_DEPTH; d++) send_packed_line(d, "b");
    send_packed_line(STACK_DEPTH + 8, "c");
    send_line(1, "d");
    send_line(0, "e");
  endtask

  // The receiver holds off for a long stretch while dedents keep coming,
  // then the sender pauses until every event has arrived.
  task automatic test_backpressure();
    drain_results();
    bursty  = 1'b0;
    rx_mode = RX_ALWAYS;
    send_line(0, "a");
    for (int d = 1; d <= 6; d++) send_line(d, "b");
    holdoff_req++;
    repeat (2) begin
      send_line(0, "c");
      for (int d = 1; d <= 4; d++) send_line(2 * d, "d");
    end
    send_line(0, "e");
    drain_results();
  endtask

  // Random lines in three phases, each with its own tab width and idling.
  task automatic test_random_lines();
    int target;
    for (int phase = 0; phase < 3; phase++) begin
      drain_results();
      write_tab_width(5'($urandom_range(1, 16)));
      bursty  = (phase != 0);
      rx_mode = (phase == 0) ? RX_ALWAYS : (phase == 1) ? RX_RANDOM : RX_PATTERN;
      target  = bytes_used + 25;
      while (bytes_used < target) send_random_line();
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    bursty  = 1'b1;
    rx_mode = RX_RANDOM;
    test_nesting();
    test_whitespace();
    test_comments();
    test_tab_widths();
    test_stack_limits();
    test_backpressure();
    test_random_lines();
    drain_results();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
